// File: hw/rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants for the genome compatibility distance block.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int MAX_GENES = 1024;
  localparam int CNT_W     = $clog2(MAX_GENES + 1);
  localparam int MARK_W    = 32;
  localparam int WGT_W     = 32;
  localparam int IMP_W     = 16;
  localparam int SUM_W     = 48;
  localparam int HALF_W    = SUM_W / 2;
  localparam int PROD_W    = SUM_W + IMP_W;
  localparam int FRAC_W    = 8;
  localparam int QUO_W     = PROD_W - FRAC_W;
  localparam int DTERM_W   = CNT_W + 1 + IMP_W;
  localparam int DIST_W    = 63;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DISJOINT_IMP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_IMP   = CFG_IDX_W'(1);
  localparam logic [IMP_W-1:0]     IMP_RESET        = IMP_W'(256);

  typedef enum logic [2:0] {
    S_ACCUM,
    S_MUL,
    S_SUM,
    S_DIV,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic accept;     // item taken this cycle
    logic mul;        // form the partial products
    logic sum;        // combine products, set up divider
    logic div_step;   // one quotient bit
    logic load;       // capture result, clear accumulators
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

// File: hw/rtl/gcd_ctrl.sv
// ----------------------------------------------------------------------------
// gcd_ctrl
// Sequencer: accumulate, multiply, combine, divide, load result; owns output valid.
// ----------------------------------------------------------------------------
module gcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              last_pair,
  output logic              out_valid,
  input  logic              out_ready,
  input  gcd_pkg::status_t  status,
  output gcd_pkg::cmd_t     cmd
);

  gcd_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gcd_pkg::S_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      gcd_pkg::S_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && last_pair) state_next = gcd_pkg::S_MUL;
      end
      gcd_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = gcd_pkg::S_SUM;
      end
      gcd_pkg::S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = gcd_pkg::S_DIV;
      end
      gcd_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = gcd_pkg::S_LOAD;
      end
      gcd_pkg::S_LOAD: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = gcd_pkg::S_ACCUM;
        end
      end
      default: state_next = gcd_pkg::S_ACCUM;
    endcase
  end

endmodule

// File: hw/rtl/gcd_datapath.sv
// ----------------------------------------------------------------------------
// gcd_datapath
// Gene counters, weight difference sum, products, serial divider, result.
// ----------------------------------------------------------------------------
module gcd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  gcd_pkg::cmd_t                     cmd,
  output gcd_pkg::status_t                  status,
  input  logic                              cfg_write,
  input  logic [gcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcd_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                              has_gene_a,
  input  logic                              has_gene_b,
  input  logic [gcd_pkg::MARK_W-1:0]        marking_a,
  input  logic [gcd_pkg::MARK_W-1:0]        marking_b,
  input  logic signed [gcd_pkg::WGT_W-1:0]  weight_a,
  input  logic signed [gcd_pkg::WGT_W-1:0]  weight_b,
  output logic [gcd_pkg::DIST_W-1:0]        distance,
  output logic                              no_overlap,
  output logic [gcd_pkg::CNT_W-1:0]         overlap_count
);

  localparam int CNT_W  = gcd_pkg::CNT_W;
  localparam int SUM_W  = gcd_pkg::SUM_W;
  localparam int HALF_W = gcd_pkg::HALF_W;
  localparam int PROD_W = gcd_pkg::PROD_W;
  localparam int QUO_W  = gcd_pkg::QUO_W;
  localparam int IMP_W  = gcd_pkg::IMP_W;
  localparam int DT_W   = gcd_pkg::DTERM_W;
  localparam int DC_W   = gcd_pkg::DIV_CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(gcd_pkg::MAX_GENES);

  logic [IMP_W-1:0]  disjoint_imp, weight_imp;
  logic [CNT_W-1:0]  count_a, count_b, overlap;
  logic [SUM_W-1:0]  diff_sum;
  logic              still_matching;

  logic [HALF_W+IMP_W-1:0] prod_lo, prod_hi;
  logic [DT_W-1:0]         dterm;
  logic [QUO_W-1:0]        quo;
  logic [CNT_W-1:0]        rem;
  logic [DC_W-1:0]         div_cnt;

  logic signed [gcd_pkg::WGT_W:0] wdiff;
  logic [gcd_pkg::WGT_W-1:0]      wabs;
  logic [SUM_W:0]                 sum_ext;
  logic                           match;
  logic [CNT_W:0]                 both, twice_ov, disjoint;
  logic [PROD_W-1:0]              prod_full;
  logic [CNT_W:0]                 trial;
  logic                           trial_ge;
  logic [QUO_W:0]                 dist_sum;

  always_comb begin
    wdiff    = (gcd_pkg::WGT_W+1)'(weight_a) - (gcd_pkg::WGT_W+1)'(weight_b);
    wabs     = wdiff[gcd_pkg::WGT_W] ? gcd_pkg::WGT_W'(-wdiff)
                                     : wdiff[gcd_pkg::WGT_W-1:0];
    sum_ext  = {1'b0, diff_sum} + (SUM_W+1)'(wabs);
    match    = still_matching && has_gene_a && has_gene_b && (marking_a == marking_b);
    both     = {1'b0, count_a} + {1'b0, count_b};
    twice_ov = {overlap, 1'b0};
    disjoint = (both > twice_ov) ? both - twice_ov : '0;
    prod_full = PROD_W'(prod_lo) + {prod_hi, {HALF_W{1'b0}}};
    trial    = {rem, quo[QUO_W-1]};
    trial_ge = trial >= {1'b0, overlap};
    // both terms fit within the 57-bit sum, so the sum cannot overflow
    dist_sum = (QUO_W+1)'({dterm, {gcd_pkg::FRAC_W{1'b0}}}) + (QUO_W+1)'(quo);
  end

  assign status.div_done = (div_cnt == DC_W'(QUO_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      disjoint_imp <= gcd_pkg::IMP_RESET;
      weight_imp   <= gcd_pkg::IMP_RESET;
    end else if (cfg_write) begin
      if (cfg_index == gcd_pkg::REG_DISJOINT_IMP) disjoint_imp <= cfg_data;
      if (cfg_index == gcd_pkg::REG_WEIGHT_IMP)   weight_imp   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      count_a        <= '0;
      count_b        <= '0;
      overlap        <= '0;
      diff_sum       <= '0;
      still_matching <= 1'b1;
    end else if (cmd.accept) begin
      if (has_gene_a && count_a < CNT_MAX) count_a <= count_a + 1'b1;
      if (has_gene_b && count_b < CNT_MAX) count_b <= count_b + 1'b1;
      if (match) begin
        diff_sum <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        if (overlap < CNT_MAX) overlap <= overlap + 1'b1;
      end else begin
        still_matching <= 1'b0;
      end
    end
  end

  // finalize: split product, then restoring division by overlap
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_lo <= diff_sum[HALF_W-1:0] * weight_imp;
      prod_hi <= diff_sum[SUM_W-1:HALF_W] * weight_imp;
      dterm   <= disjoint * disjoint_imp;
    end
    if (cmd.sum) begin
      quo     <= prod_full[PROD_W-1:gcd_pkg::FRAC_W];
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? CNT_W'(trial - {1'b0, overlap}) : trial[CNT_W-1:0];
      quo     <= {quo[QUO_W-2:0], trial_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.load) begin
      no_overlap    <= (overlap == '0);
      overlap_count <= overlap;
      distance      <= (overlap == '0) ? gcd_pkg::DIST_W'({dterm, {gcd_pkg::FRAC_W{1'b0}}})
                                       : gcd_pkg::DIST_W'(dist_sum);
    end
  end

endmodule

// File: hw/rtl/genome_compatibility_distance.sv
// ----------------------------------------------------------------------------
// genome_compatibility_distance
// Compatibility distance of two genomes from a stream of gene pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one gene pair per request, one
//   per cycle while accumulating. A request with last_pair closes the
//   comparison; in_ready then stays low through the product step, the
//   combine step, the one-bit-per-cycle restoring divider (56-bit quotient
//   of the scaled product) and the load step.
//   Result channel (out_valid/out_ready) carries distance, no_overlap and
//   overlap_count from an output register, loaded in the load step once the
//   divider is done. Accumulation of the next genome pair runs while a result
//   waits; if the receiver stalls, the next result holds in the load state
//   until the register frees.
//   Config channel (cfg_valid/cfg_ready, always ready) writes index 0
//   disjoint importance, index 1 weight importance (Q8.8); other indexes are
//   ignored. Write only while idle.
//   Reset (rst, synchronous) clears counters and sums, sets both importances
//   to 1.0 and empties the output register.
// ----------------------------------------------------------------------------
module genome_compatibility_distance (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcd_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              has_gene_a,
  input  logic                              has_gene_b,
  input  logic [gcd_pkg::MARK_W-1:0]        marking_a,
  input  logic [gcd_pkg::MARK_W-1:0]        marking_b,
  input  logic signed [gcd_pkg::WGT_W-1:0]  weight_a,
  input  logic signed [gcd_pkg::WGT_W-1:0]  weight_b,
  input  logic                              last_pair,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcd_pkg::DIST_W-1:0]        distance,
  output logic                              no_overlap,
  output logic [gcd_pkg::CNT_W-1:0]         overlap_count
);

  gcd_pkg::cmd_t    cmd;
  gcd_pkg::status_t status;

  assign cfg_ready = 1'b1;

  gcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_pair (last_pair),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gcd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .has_gene_a    (has_gene_a),
    .has_gene_b    (has_gene_b),
    .marking_a     (marking_a),
    .marking_b     (marking_b),
    .weight_a      (weight_a),
    .weight_b      (weight_b),
    .distance      (distance),
    .no_overlap    (no_overlap),
    .overlap_count (overlap_count)
  );

endmodule
